// ----- rtl/core/assert_macros.svh -----
// assertion macros used by the compositing rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define BHLC_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the next cycle
`define BHLC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/bhlc_pkg.sv -----
// shared types and constants of the behind-layer compositor
package bhlc_pkg;

   // default channel width, unsigned fraction bits
   localparam int CH_BITS_DEF = 16;

   // register port geometry
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;

   // opacity register
   localparam int OPACITY_BITS = 16;
   localparam logic [OPACITY_BITS-1:0] OPACITY_RESET = '1;

   // register indexes, byte address is four times the index
   localparam logic [1:0] REG_MODE    = 2'd0;
   localparam logic [1:0] REG_OPACITY = 2'd1;
   localparam logic [1:0] REG_MASK_EN = 2'd2;

   // composite modes
   typedef enum logic [1:0] {
      MODE_UNION      = 2'd0,
      MODE_CLIP_BACK  = 2'd1,
      MODE_CLIP_LAYER = 2'd2,
      MODE_INTERSECT  = 2'd3
   } mode_type;

   localparam mode_type MODE_RESET = MODE_UNION;

endpackage

// ----- rtl/core/bhlc_qmul.sv -----
// two-stage fixed-point multiply with round to nearest, scaled by 1/(2^n - 1)
module bhlc_qmul #(
   parameter int CHANNEL_BITS = bhlc_pkg::CH_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    en,
   input  logic [CHANNEL_BITS-1:0] op_a,
   input  logic [CHANNEL_BITS-1:0] op_b,
   output logic [CHANNEL_BITS-1:0] prod_q
);

   localparam int CB = CHANNEL_BITS;
   localparam int W  = 2 * CB;
   localparam logic [CB-1:0] MAXV = '1;
   localparam logic [W-1:0]  HALF = W'(MAXV >> 1);

   logic [W-1:0]  prod_in, prod_ff;
   logic [W:0]    est_sum;
   logic [CB:0]   est;
   logic [W:0]    rem;
   logic [CB-1:0] q_in, q_ff;

   // stage one: raw product plus rounding half
   assign prod_in = W'(op_a) * W'(op_b) + HALF;

   // stage two: divide by all-ones, estimate never overshoots, one fix-up
   assign est_sum = {1'b0, prod_ff} + (W + 1)'(prod_ff >> CB);
   assign est     = est_sum[W:CB];
   assign rem     = {1'b0, prod_ff} - ((W + 1)'(est) << CB) + (W + 1)'(est);
   assign q_in    = (rem >= (W + 1)'(MAXV)) ? CB'(est + 1'b1) : CB'(est);

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
         q_ff    <= q_in;
      end
   end

   assign prod_q = q_ff;

endmodule

// ----- rtl/core/bhlc_div.sv -----
// pipelined restoring divider, one quotient bit per stage
module bhlc_div #(
   parameter int CHANNEL_BITS = bhlc_pkg::CH_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    en,
   input  logic [CHANNEL_BITS-1:0] num_hi,
   input  logic [CHANNEL_BITS-1:0] num_lo,
   input  logic [CHANNEL_BITS-1:0] den,
   output logic [CHANNEL_BITS-1:0] quo
);

   localparam int CB = CHANNEL_BITS;

   logic [CB-1:0] rem_ff [CB];
   logic [CB-1:0] lo_ff  [CB];
   logic [CB-1:0] den_ff [CB];
   logic [CB-1:0] quo_ff [CB];
   logic [CB-1:0] rem_in [CB];
   logic [CB-1:0] lo_in  [CB];
   logic [CB-1:0] den_in [CB];
   logic [CB-1:0] quo_in [CB];

   genvar k;
   generate
      for (k = 0; k < CB; k++) begin : g_step
         logic [CB-1:0] r_src, l_src, d_src, q_src;
         logic [CB:0]   trial;
         logic          fits;

         // operands come from the port or the previous step
         if (k == 0) begin : g_first
            assign r_src = num_hi;
            assign l_src = num_lo;
            assign d_src = den;
            assign q_src = '0;
         end else begin : g_next
            assign r_src = rem_ff[k-1];
            assign l_src = lo_ff[k-1];
            assign d_src = den_ff[k-1];
            assign q_src = quo_ff[k-1];
         end

         // shift in next dividend bit, subtract when it fits
         assign trial     = {r_src, l_src[CB-1]};
         assign fits      = (trial >= {1'b0, d_src});
         assign rem_in[k] = fits ? CB'(trial - {1'b0, d_src}) : CB'(trial);
         assign lo_in[k]  = l_src << 1;
         assign den_in[k] = d_src;
         assign quo_in[k] = {q_src[CB-2:0], fits};
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < CB; i++) begin
            rem_ff[i] <= rem_in[i];
            lo_ff[i]  <= lo_in[i];
            den_ff[i] <= den_in[i];
            quo_ff[i] <= quo_in[i];
         end
      end
   end

   assign quo = quo_ff[CB-1];

endmodule

// ----- rtl/core/bhlc_lane.sv -----
// one colour lane: union mix, lerp toward backdrop and mode select
module bhlc_lane #(
   parameter int CHANNEL_BITS = bhlc_pkg::CH_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    en,
   input  bhlc_pkg::mode_type      mode,
   input  logic [CHANNEL_BITS-1:0] back,
   input  logic [CHANNEL_BITS-1:0] lay,
   input  logic [CHANNEL_BITS-1:0] ratio,
   input  logic [CHANNEL_BITS-1:0] back_alpha,
   output logic [CHANNEL_BITS-1:0] colour
);

   localparam int CB = CHANNEL_BITS;
   localparam logic [CB-1:0] MAXV = '1;

   logic          up;
   logic [CB-1:0] diff;
   logic [CB-1:0] mix_bk, mix_ly, step;
   logic [CB-1:0] bk_ff [2];
   logic [CB-1:0] ly_ff [2];
   logic          up_ff [2];
   logic [CB:0]   mix_sum;
   logic [CB-1:0] mix_sat, lerp;
   logic [CB-1:0] res_in, res_ff;

   // distance between layer and backdrop, with direction
   assign up   = (back >= lay);
   assign diff = up ? (back - lay) : (lay - back);

   bhlc_qmul #(.CHANNEL_BITS(CB)) u_mul_bk (
      .clock(clock), .en(en), .op_a(back), .op_b(ratio), .prod_q(mix_bk)
   );

   bhlc_qmul #(.CHANNEL_BITS(CB)) u_mul_ly (
      .clock(clock), .en(en), .op_a(lay), .op_b(MAXV - ratio), .prod_q(mix_ly)
   );

   bhlc_qmul #(.CHANNEL_BITS(CB)) u_mul_lerp (
      .clock(clock), .en(en), .op_a(diff), .op_b(back_alpha), .prod_q(step)
   );

   // keep operands in step with the multipliers
   always_ff @(posedge clock) begin
      if (en) begin
         bk_ff[0] <= back;
         ly_ff[0] <= lay;
         up_ff[0] <= up;
         bk_ff[1] <= bk_ff[0];
         ly_ff[1] <= ly_ff[0];
         up_ff[1] <= up_ff[0];
      end
   end

   // saturating union sum and lerp result
   assign mix_sum = {1'b0, mix_bk} + {1'b0, mix_ly};
   assign mix_sat = (mix_sum > {1'b0, MAXV}) ? MAXV : mix_sum[CB-1:0];
   assign lerp    = up_ff[1] ? (ly_ff[1] + step) : (ly_ff[1] - step);

   // pick the colour that the mode asks for
   always_comb begin
      unique case (mode)
         bhlc_pkg::MODE_UNION:      res_in = mix_sat;
         bhlc_pkg::MODE_CLIP_LAYER: res_in = lerp;
         bhlc_pkg::MODE_CLIP_BACK:  res_in = bk_ff[1];
         bhlc_pkg::MODE_INTERSECT:  res_in = bk_ff[1];
         default:                   res_in = bk_ff[1];
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff <= res_in;
      end
   end

   assign colour = res_ff;

endmodule

// ----- rtl/core/behind_layer_composite_top.sv -----
// behind-layer compositor top: register port, alpha path, divider, lanes, output
//
// Paints a layer pixel behind a backdrop pixel, one RGBA pixel per word.
// Input words arrive on the req_ channel and results leave on the rsp_
// channel, both valid/ready; last_in travels with its pixel to last_out.
// The csr_ port holds composite mode, layer opacity and mask enable; write
// it only while no pixel is in flight.
// A pixel passes, in order, three alpha multiplies (the first product taken
// at the accepting edge), the alpha select registers, the one-bit-per-stage
// ratio divider, the colour lanes and the output register, which drives rsp_valid.
// Throughput is one word per clock while no skid word is held; the divider
// and lanes are fully pipelined and nothing is kept from one pixel to the next.
// Reset clears the pipeline valid bits, the output and skid valid bits and
// loads the register defaults (union mode, full opacity, mask off);
// req_ready stays low while reset is high.
// When the receiver stalls, one more word is taken into a skid register,
// then req_ready drops and the whole pipeline holds until it drains.
`include "assert_macros.svh"

module behind_layer_composite_top #(
   parameter int CHANNEL_BITS = bhlc_pkg::CH_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // input pixels
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [CHANNEL_BITS-1:0]            req_back_red,
   input  logic [CHANNEL_BITS-1:0]            req_back_green,
   input  logic [CHANNEL_BITS-1:0]            req_back_blue,
   input  logic [CHANNEL_BITS-1:0]            req_back_alpha,
   input  logic [CHANNEL_BITS-1:0]            req_layer_red,
   input  logic [CHANNEL_BITS-1:0]            req_layer_green,
   input  logic [CHANNEL_BITS-1:0]            req_layer_blue,
   input  logic [CHANNEL_BITS-1:0]            req_layer_alpha,
   input  logic [CHANNEL_BITS-1:0]            req_mask_value,
   input  logic                               req_last_in,
   // result pixels
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [CHANNEL_BITS-1:0]            rsp_out_red,
   output logic [CHANNEL_BITS-1:0]            rsp_out_green,
   output logic [CHANNEL_BITS-1:0]            rsp_out_blue,
   output logic [CHANNEL_BITS-1:0]            rsp_out_alpha,
   output logic                               rsp_last_out,
   // register port
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [bhlc_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [bhlc_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [bhlc_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                               csr_pready
);

   localparam int CB = CHANNEL_BITS;
   localparam int S  = CB + 10;
   localparam int AL = CB + 4;
   localparam int OW = 4 * CB + 1;
   localparam int DW = bhlc_pkg::CSR_DATA_BITS;
   localparam logic [CB-1:0] MAXV = '1;

   // registers
   bhlc_pkg::mode_type                  mode_ff;
   logic [bhlc_pkg::OPACITY_BITS-1:0]   opac_ff;
   logic                                mask_en_ff;
   logic [CB-1:0]                       opac_ch;
   logic                                csr_wr;
   logic [1:0]                          csr_idx;

   // pipeline
   logic          en;
   logic          vld_ff  [S];
   logic [CB-1:0] bk_ff   [S][3];
   logic [CB-1:0] ly_ff   [S][3];
   logic [CB-1:0] ba_ff   [S];
   logic          last_ff [S];
   logic [CB-1:0] msk_ff  [2];

   // alpha path
   logic [CB-1:0] la1, la_m, la4, t6, ai6;
   logic [CB-1:0] la1_ff [2];
   logic [CB-1:0] la_ff  [2];
   logic [CB:0]   un_sum;
   logic [CB-1:0] alpha_u, alpha_in;
   logic          cap_in;
   logic [2*CB-1:0] num_in, num_ff;
   logic [CB-1:0] den_ff;
   logic [CB-1:0] aln_ff [AL];
   logic          cap_ff [CB+1];
   logic [CB-1:0] quo, ratio;

   // lanes and merge
   logic [CB-1:0] col [3];
   logic [CB-1:0] pix [3];
   logic          zero_alpha;
   logic [OW-1:0] merged;

   // output and skid
   logic          out_v_in, out_v_ff, skid_v_in, skid_v_ff;
   logic          out_ld, skid_ld;
   logic [OW-1:0] out_d_in, out_d_ff, skid_d_ff;

   // register port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_idx    = csr_paddr[bhlc_pkg::CSR_ADDR_BITS-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= bhlc_pkg::MODE_RESET;
         opac_ff    <= bhlc_pkg::OPACITY_RESET;
         mask_en_ff <= 1'b0;
      end else if (csr_wr) begin
         unique case (csr_idx)
            bhlc_pkg::REG_MODE:    mode_ff    <= bhlc_pkg::mode_type'(csr_pwdata[1:0]);
            bhlc_pkg::REG_OPACITY: opac_ff    <= csr_pwdata[bhlc_pkg::OPACITY_BITS-1:0];
            bhlc_pkg::REG_MASK_EN: mask_en_ff <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   // register readback
   always_comb begin
      unique case (csr_idx)
         bhlc_pkg::REG_MODE:    csr_prdata = DW'(mode_ff);
         bhlc_pkg::REG_OPACITY: csr_prdata = DW'(opac_ff);
         bhlc_pkg::REG_MASK_EN: csr_prdata = DW'(mask_en_ff);
         default:               csr_prdata = '0;
      endcase
   end

   assign opac_ch = CB'(opac_ff);

   // whole pipeline advances unless the skid word is held
   assign en        = ~skid_v_ff;
   assign req_ready = en & ~reset;

   // valid line
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < S; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else if (en) begin
         vld_ff[0] <= req_valid;
         for (int k = 1; k < S; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   // pixel payload line
   always_ff @(posedge clock) begin
      if (en) begin
         bk_ff[0][0] <= req_back_red;
         bk_ff[0][1] <= req_back_green;
         bk_ff[0][2] <= req_back_blue;
         ly_ff[0][0] <= req_layer_red;
         ly_ff[0][1] <= req_layer_green;
         ly_ff[0][2] <= req_layer_blue;
         ba_ff[0]    <= req_back_alpha;
         last_ff[0]  <= req_last_in;
         msk_ff[0]   <= req_mask_value;
         msk_ff[1]   <= msk_ff[0];
         for (int k = 1; k < S; k++) begin
            bk_ff[k]   <= bk_ff[k-1];
            ly_ff[k]   <= ly_ff[k-1];
            ba_ff[k]   <= ba_ff[k-1];
            last_ff[k] <= last_ff[k-1];
         end
      end
   end

   // layer alpha scaled by opacity
   bhlc_qmul #(.CHANNEL_BITS(CB)) u_mul_opac (
      .clock(clock), .en(en), .op_a(req_layer_alpha), .op_b(opac_ch), .prod_q(la1)
   );

   // then by the mask value
   bhlc_qmul #(.CHANNEL_BITS(CB)) u_mul_mask (
      .clock(clock), .en(en), .op_a(la1), .op_b(msk_ff[1]), .prod_q(la_m)
   );

   assign la4 = mask_en_ff ? la_m : la1_ff[1];

   // union term and intersection alpha
   bhlc_qmul #(.CHANNEL_BITS(CB)) u_mul_union (
      .clock(clock), .en(en), .op_a(MAXV - la4), .op_b(ba_ff[3]), .prod_q(t6)
   );

   bhlc_qmul #(.CHANNEL_BITS(CB)) u_mul_isect (
      .clock(clock), .en(en), .op_a(la4), .op_b(ba_ff[3]), .prod_q(ai6)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         la1_ff[0] <= la1;
         la1_ff[1] <= la1_ff[0];
         la_ff[0]  <= la4;
         la_ff[1]  <= la_ff[0];
      end
   end

   // union alpha, ratio cap and divider operands
   assign un_sum  = {1'b0, la_ff[1]} + {1'b0, t6};
   assign alpha_u = (un_sum > {1'b0, MAXV}) ? MAXV : un_sum[CB-1:0];
   assign cap_in  = (ba_ff[5] >= alpha_u);
   assign num_in  = {ba_ff[5], {CB{1'b0}}} - {{CB{1'b0}}, ba_ff[5]};

   // result alpha per mode
   always_comb begin
      unique case (mode_ff)
         bhlc_pkg::MODE_UNION:      alpha_in = alpha_u;
         bhlc_pkg::MODE_CLIP_BACK:  alpha_in = ba_ff[5];
         bhlc_pkg::MODE_CLIP_LAYER: alpha_in = la_ff[1];
         bhlc_pkg::MODE_INTERSECT:  alpha_in = ai6;
         default:                   alpha_in = alpha_u;
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         aln_ff[0] <= alpha_in;
         cap_ff[0] <= cap_in;
         num_ff    <= num_in;
         den_ff    <= alpha_u;
         for (int k = 1; k < AL; k++) begin
            aln_ff[k] <= aln_ff[k-1];
         end
         for (int k = 1; k <= CB; k++) begin
            cap_ff[k] <= cap_ff[k-1];
         end
      end
   end

   // backdrop share of the colour, backdrop alpha over union alpha
   bhlc_div #(.CHANNEL_BITS(CB)) u_div (
      .clock  (clock),
      .en     (en),
      .num_hi (num_ff[2*CB-1:CB]),
      .num_lo (num_ff[CB-1:0]),
      .den    (den_ff),
      .quo    (quo)
   );

   assign ratio = cap_ff[CB] ? MAXV : quo;

   // colour lanes
   genvar c;
   generate
      for (c = 0; c < 3; c++) begin : g_lane
         bhlc_lane #(.CHANNEL_BITS(CB)) u_lane (
            .clock      (clock),
            .en         (en),
            .mode       (mode_ff),
            .back       (bk_ff[CB+6][c]),
            .lay        (ly_ff[CB+6][c]),
            .ratio      (ratio),
            .back_alpha (ba_ff[CB+6]),
            .colour     (col[c])
         );
         assign pix[c] = zero_alpha ? ly_ff[S-1][c] : col[c];
      end
   endgenerate

   // merge: zero alpha passes the layer colour
   assign zero_alpha = (aln_ff[AL-1] == '0);
   assign merged     = {pix[0], pix[1], pix[2], aln_ff[AL-1], last_ff[S-1]};

   // output register with one-word skid
   always_comb begin
      out_v_in  = out_v_ff;
      skid_v_in = skid_v_ff;
      out_d_in  = out_d_ff;
      out_ld    = 1'b0;
      skid_ld   = 1'b0;
      if (skid_v_ff) begin
         if (rsp_ready) begin
            out_d_in  = skid_d_ff;
            out_ld    = 1'b1;
            skid_v_in = 1'b0;
         end
      end else if (vld_ff[S-1]) begin
         if (!out_v_ff || rsp_ready) begin
            out_d_in = merged;
            out_ld   = 1'b1;
            out_v_in = 1'b1;
         end else begin
            skid_ld   = 1'b1;
            skid_v_in = 1'b1;
         end
      end else if (rsp_ready) begin
         out_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         out_v_ff  <= out_v_in;
         skid_v_ff <= skid_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ld) begin
         out_d_ff <= out_d_in;
      end
      if (skid_ld) begin
         skid_d_ff <= merged;
      end
   end

   assign rsp_valid     = out_v_ff;
   assign rsp_out_red   = out_d_ff[4*CB:3*CB+1];
   assign rsp_out_green = out_d_ff[3*CB:2*CB+1];
   assign rsp_out_blue  = out_d_ff[2*CB:CB+1];
   assign rsp_out_alpha = out_d_ff[CB:1];
   assign rsp_last_out  = out_d_ff[0];

   // checks on the output and skid stage
   `BHLC_ASSERT_SAME(a_skid_behind_out, skid_v_ff, out_v_ff, "skid word without output word")
   `BHLC_ASSERT_NEXT(a_stall_fills_skid, vld_ff[S-1] && !skid_v_ff && out_v_ff && !rsp_ready, skid_v_ff, "stalled word not caught in skid")
   `BHLC_ASSERT_NEXT(a_skid_drains, skid_v_ff && rsp_ready, !skid_v_ff && out_v_ff, "skid word not moved to output")

endmodule

// ----- tb/tb_behind_layer_composite_top.sv -----
// self-checking testbench for the behind-layer compositor: predicts each pixel and compares
module tb_behind_layer_composite_top;

   localparam int CH = 16;
   localparam logic [63:0] CODE_MAX = 64'd65535;
   localparam int STUCK_LIMIT = 5000;

   typedef struct packed {
      logic [CH-1:0] back_red;
      logic [CH-1:0] back_green;
      logic [CH-1:0] back_blue;
      logic [CH-1:0] back_alpha;
      logic [CH-1:0] layer_red;
      logic [CH-1:0] layer_green;
      logic [CH-1:0] layer_blue;
      logic [CH-1:0] layer_alpha;
      logic [CH-1:0] mask_value;
      logic          last_in;
   } pixel_type;

   typedef struct packed {
      logic [CH-1:0] red;
      logic [CH-1:0] green;
      logic [CH-1:0] blue;
      logic [CH-1:0] alpha;
      logic          last_out;
   } blended_type;

   logic clock;
   logic reset = 1'b1;

   logic          req_valid = 1'b0;
   logic          req_ready;
   logic [CH-1:0] req_back_red = '0;
   logic [CH-1:0] req_back_green = '0;
   logic [CH-1:0] req_back_blue = '0;
   logic [CH-1:0] req_back_alpha = '0;
   logic [CH-1:0] req_layer_red = '0;
   logic [CH-1:0] req_layer_green = '0;
   logic [CH-1:0] req_layer_blue = '0;
   logic [CH-1:0] req_layer_alpha = '0;
   logic [CH-1:0] req_mask_value = '0;
   logic          req_last_in = 1'b0;

   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   logic [CH-1:0] rsp_out_red;
   logic [CH-1:0] rsp_out_green;
   logic [CH-1:0] rsp_out_blue;
   logic [CH-1:0] rsp_out_alpha;
   logic          rsp_last_out;

   logic                               csr_psel = 1'b0;
   logic                               csr_penable = 1'b0;
   logic                               csr_pwrite = 1'b0;
   logic [bhlc_pkg::CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [bhlc_pkg::CSR_DATA_BITS-1:0] csr_pwdata = '0;
   logic [bhlc_pkg::CSR_DATA_BITS-1:0] csr_prdata;
   logic                               csr_pready;

   // local copy of the register file
   bhlc_pkg::mode_type cur_mode = bhlc_pkg::MODE_RESET;
   logic [CH-1:0]      cur_opacity = bhlc_pkg::OPACITY_RESET;
   logic               cur_mask_en = 1'b0;

   blended_type expected_pixels[$];
   int          fail_count = 0;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   int          stuck_cycles = 0;

   behind_layer_composite_top dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_back_red(req_back_red),
      .req_back_green(req_back_green),
      .req_back_blue(req_back_blue),
      .req_back_alpha(req_back_alpha),
      .req_layer_red(req_layer_red),
      .req_layer_green(req_layer_green),
      .req_layer_blue(req_layer_blue),
      .req_layer_alpha(req_layer_alpha),
      .req_mask_value(req_mask_value),
      .req_last_in(req_last_in),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_out_red(rsp_out_red),
      .rsp_out_green(rsp_out_green),
      .rsp_out_blue(rsp_out_blue),
      .rsp_out_alpha(rsp_out_alpha),
      .rsp_last_out(rsp_last_out),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // fixed-point product rounded to the nearest code
   function automatic logic [63:0] q_mul(logic [63:0] a, logic [63:0] b);
      return (a * b + (CODE_MAX >> 1)) / CODE_MAX;
   endfunction

   // move the layer channel toward the backdrop by t, rounding the step magnitude
   function automatic logic [63:0] lerp_toward(logic [63:0] lay, logic [63:0] bk,
                                               logic [63:0] t);
      if (bk >= lay) begin
         return lay + q_mul(bk - lay, t);
      end
      return lay - q_mul(lay - bk, t);
   endfunction

   // expected result pixel for the current register settings
   function automatic blended_type composite_behind(pixel_type p);
      logic [63:0] back[3];
      logic [63:0] lay[3];
      logic [63:0] res[3];
      logic [63:0] ba, la, alpha, ratio, mix;
      blended_type q;
      back[0] = 64'(p.back_red);
      back[1] = 64'(p.back_green);
      back[2] = 64'(p.back_blue);
      lay[0] = 64'(p.layer_red);
      lay[1] = 64'(p.layer_green);
      lay[2] = 64'(p.layer_blue);
      res = lay;
      ba = 64'(p.back_alpha);
      la = q_mul(64'(p.layer_alpha), 64'(cur_opacity));
      if (cur_mask_en) begin
         la = q_mul(la, 64'(p.mask_value));
      end
      unique case (cur_mode)
         bhlc_pkg::MODE_UNION: begin
            alpha = la + q_mul(CODE_MAX - la, ba);
            if (alpha > CODE_MAX) alpha = CODE_MAX;
            if (alpha != 0) begin
               ratio = (ba * CODE_MAX) / alpha;
               if (ratio > CODE_MAX) ratio = CODE_MAX;
               for (int c = 0; c < 3; c++) begin
                  mix = q_mul(back[c], ratio) + q_mul(lay[c], CODE_MAX - ratio);
                  res[c] = (mix > CODE_MAX) ? CODE_MAX : mix;
               end
            end
         end
         bhlc_pkg::MODE_CLIP_BACK: begin
            alpha = ba;
            if (alpha != 0) res = back;
         end
         bhlc_pkg::MODE_CLIP_LAYER: begin
            alpha = la;
            if (alpha != 0) begin
               for (int c = 0; c < 3; c++) res[c] = lerp_toward(lay[c], back[c], ba);
            end
         end
         default: begin
            alpha = q_mul(ba, la);
            if (alpha != 0) res = back;
         end
      endcase
      // zero coverage passes the layer colour
      if (alpha == 0) res = lay;
      q.red = res[0][CH-1:0];
      q.green = res[1][CH-1:0];
      q.blue = res[2][CH-1:0];
      q.alpha = alpha[CH-1:0];
      q.last_out = p.last_in;
      return q;
   endfunction

   function automatic pixel_type make_pixel(int br, int bg, int bb, int ba,
                                            int lr, int lg, int lb, int la,
                                            int mv, bit last);
      pixel_type p;
      p.back_red = CH'(br);
      p.back_green = CH'(bg);
      p.back_blue = CH'(bb);
      p.back_alpha = CH'(ba);
      p.layer_red = CH'(lr);
      p.layer_green = CH'(lg);
      p.layer_blue = CH'(lb);
      p.layer_alpha = CH'(la);
      p.mask_value = CH'(mv);
      p.last_in = last;
      return p;
   endfunction

   // code biased toward the ends of the range
   function automatic int random_code();
      unique case ($urandom_range(7))
         0: return 0;
         1: return 65535;
         2: return $urandom_range(3);
         3: return 65535 - $urandom_range(3);
         default: return $urandom_range(65535);
      endcase
   endfunction

   function automatic pixel_type random_pixel();
      return make_pixel(random_code(), random_code(), random_code(), random_code(),
                        random_code(), random_code(), random_code(), random_code(),
                        random_code(), 1'($urandom_range(1)));
   endfunction

   // send one pixel word and record its expected result once accepted
   task automatic send_pixel(input pixel_type p);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_back_red <= p.back_red;
      req_back_green <= p.back_green;
      req_back_blue <= p.back_blue;
      req_back_alpha <= p.back_alpha;
      req_layer_red <= p.layer_red;
      req_layer_green <= p.layer_green;
      req_layer_blue <= p.layer_blue;
      req_layer_alpha <= p.layer_alpha;
      req_mask_value <= p.mask_value;
      req_last_in <= p.last_in;
      do @(posedge clock); while (!req_ready);
      expected_pixels.push_back(composite_behind(p));
   endtask

   // stop sending and wait for every outstanding pixel
   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      unique case (idx)
         bhlc_pkg::REG_MODE: cur_mode = bhlc_pkg::mode_type'(value[1:0]);
         bhlc_pkg::REG_OPACITY: cur_opacity = value[CH-1:0];
         default: cur_mask_en = value[0];
      endcase
   endtask

   task automatic csr_expect(input logic [1:0] idx, input logic [31:0] want);
      logic [31:0] got;
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= {idx, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      got = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      if (got !== want) begin
         $error("register %0d: expected %0d, got %0d", idx, want, got);
         fail_count++;
      end
   endtask

   // registers change only with the pipeline empty
   task automatic set_register(input logic [1:0] idx, input logic [31:0] value);
      logic [31:0] masked;
      wait_for_results();
      csr_write(idx, value);
      unique case (idx)
         bhlc_pkg::REG_MODE: masked = value & 32'h3;
         bhlc_pkg::REG_OPACITY: masked = value & 32'hFFFF;
         default: masked = value & 32'h1;
      endcase
      csr_expect(idx, masked);
   endtask

   task automatic test_reset_defaults();
      csr_expect(bhlc_pkg::REG_MODE, 32'(bhlc_pkg::MODE_RESET));
      csr_expect(bhlc_pkg::REG_OPACITY, 32'(bhlc_pkg::OPACITY_RESET));
      csr_expect(bhlc_pkg::REG_MASK_EN, 32'd0);
      repeat (3) send_pixel(random_pixel());
   endtask

   task automatic test_directed_corners();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      // union at full opacity, mask off and ignored
      send_pixel(make_pixel(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_pixel(make_pixel(65535, 65535, 65535, 65535, 65535, 65535, 65535, 65535,
                            65535, 1));
      send_pixel(make_pixel(100, 200, 300, 0, 65535, 1, 30000, 65535, 0, 0));
      send_pixel(make_pixel(65535, 0, 12345, 65535, 7, 8, 9, 0, 65535, 1));
      send_pixel(make_pixel(40000, 20000, 60000, 32768, 1000, 50000, 3, 32767, 1, 0));
      // mask scales layer alpha
      set_register(bhlc_pkg::REG_MASK_EN, 32'd1);
      set_register(bhlc_pkg::REG_OPACITY, 32'd40000);
      send_pixel(make_pixel(5, 6, 7, 0, 500, 600, 700, 65535, 0, 1));
      send_pixel(make_pixel(5, 6, 7, 20000, 500, 600, 700, 65535, 65535, 0));
      set_register(bhlc_pkg::REG_MASK_EN, 32'd0);
      set_register(bhlc_pkg::REG_OPACITY, 32'd65535);
      // each of the other modes: zero backdrop alpha, layer above and below backdrop
      for (int m = 1; m < 4; m++) begin
         set_register(bhlc_pkg::REG_MODE, 32'(m));
         send_pixel(make_pixel(1111, 2222, 3333, 0, 4444, 5555, 6666, 65535, 0, 1));
         send_pixel(make_pixel(0, 100, 65535, 65535, 65535, 65435, 0, 65535, 0, 0));
         send_pixel(make_pixel(60000, 32769, 1, 32768, 1, 32767, 60000, 40000, 0, 1));
      end
      // zero opacity in intersection mode, then in union mode
      set_register(bhlc_pkg::REG_OPACITY, 32'd0);
      send_pixel(make_pixel(9, 99, 999, 30000, 123, 456, 789, 65535, 65535, 0));
      send_pixel(make_pixel(9, 99, 999, 0, 123, 456, 789, 65535, 65535, 1));
      set_register(bhlc_pkg::REG_MODE, 32'(bhlc_pkg::MODE_UNION));
      send_pixel(make_pixel(9, 99, 999, 0, 123, 456, 789, 65535, 65535, 1));
      set_register(bhlc_pkg::REG_OPACITY, 32'd65535);
   endtask

   // sender holds off until the pipeline is empty, then resumes
   task automatic test_drain_pause();
      send_idle_pct = 0;
      recv_stall_pct = 65;
      repeat (20) send_pixel(random_pixel());
      wait_for_results();
      repeat (20) send_pixel(random_pixel());
   endtask

   // sweep modes, opacity, mask and idling patterns with random pixels
   task automatic test_random_config_sweep();
      int opacity;
      int pattern;
      for (int i = 0; i < 16; i++) begin
         unique case ((i / 4) % 4)
            0: opacity = 65535;
            1: opacity = 0;
            2: opacity = $urandom_range(65535);
            default: opacity = $urandom_range(1, 255);
         endcase
         set_register(bhlc_pkg::REG_MODE, 32'(i % 4));
         set_register(bhlc_pkg::REG_OPACITY, 32'(opacity));
         set_register(bhlc_pkg::REG_MASK_EN, 32'((i / 2) % 2));
         pattern = (i + i / 4) % 4;
         send_idle_pct = (pattern == 1) ? 65 : (pattern == 3) ? 25 : 0;
         recv_stall_pct = (pattern == 2) ? 65 : (pattern == 3) ? 25 : 0;
         repeat (40) send_pixel(random_pixel());
      end
   endtask

   task automatic finish_run();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      wait_for_results();
      repeat (40) @(posedge clock);
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   endtask

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endfunction

   // compare each result word with the oldest expectation
   always @(posedge clock) begin : check_results
      blended_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_pixels.size() == 0) begin
            $error("unexpected result word: alpha %0d", rsp_out_alpha);
            fail_count++;
         end else begin
            want = expected_pixels.pop_front();
            check_field("out_red", 64'(want.red), 64'(rsp_out_red));
            check_field("out_green", 64'(want.green), 64'(rsp_out_green));
            check_field("out_blue", 64'(want.blue), 64'(rsp_out_blue));
            check_field("out_alpha", 64'(want.alpha), 64'(rsp_out_alpha));
            check_field("last_out", 64'(want.last_out), 64'(rsp_last_out));
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_psel) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_directed_corners();
      test_drain_pause();
      test_random_config_sweep();
      finish_run();
   end

endmodule
